// ===== src/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants for the sensor command packet framer.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Frame constants
  localparam logic [7:0] HDR_BYTE0 = 8'hEF;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;
  localparam logic [7:0] MIN_BUF   = 8'd12;
  localparam logic [7:0] OVERHEAD  = 8'd11;
  localparam logic [8:0] LEN_ADJ   = 9'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BSIZE = 8'd1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_INIT  = 2'd1;
  localparam logic [1:0] ST_LEN_ZERO  = 2'd2;
  localparam logic [1:0] ST_LEN_LARGE = 2'd3;

  // Command kinds handed from front to back
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Output byte positions within one command
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_HDR0   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_HDR1   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ADDR3  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ADDR2  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ADDR1  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADDR0  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ID     = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DATA   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SUM_HI = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SUM_LO = 4'd11;

  // Command queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [7:0]  data;
    logic        last;
    logic [15:0] sum;
  } cmd_t;

endpackage

// ===== src/scf_queue.sv =====
// ----------------------------------------------------------------------------
// scf_queue
// Small command queue between the classifying front and the byte emitter.
// ----------------------------------------------------------------------------
module scf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scf_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output scf_pkg::cmd_t head_o
);

  scf_pkg::cmd_t                mem_q [scf_pkg::QDEPTH];
  logic [scf_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [scf_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [scf_pkg::QPTR_W:0]     count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o  = (count_q == (scf_pkg::QPTR_W+1)'(scf_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/scf_front.sv =====
// ----------------------------------------------------------------------------
// scf_front
// Accepts input items, checks packet starts, tracks payload count and sum.
// ----------------------------------------------------------------------------
module scf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [7:0]    packet_id_i,
  input  logic [7:0]    payload_length_i,
  input  logic [7:0]    data_byte_i,
  input  logic [7:0]    buffer_size_i,
  output logic          push_o,
  output scf_pkg::cmd_t cmd_o,
  input  logic          full_i
);

  logic        in_packet_q, in_packet_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] sum_q, sum_d;

  logic        accept;
  logic [8:0]  frame_len;
  logic [15:0] start_sum, base_sum, new_sum;
  logic [7:0]  left_base, left_next;
  logic        last;
  logic [1:0]  status;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  // Classify a start item
  always_comb begin
    status = scf_pkg::ST_OK;
    if (buffer_size_i < scf_pkg::MIN_BUF) begin
      status = scf_pkg::ST_NOT_INIT;
    end else if (payload_length_i == 8'd0) begin
      status = scf_pkg::ST_LEN_ZERO;
    end else if (payload_length_i > (buffer_size_i - scf_pkg::OVERHEAD)) begin
      status = scf_pkg::ST_LEN_LARGE;
    end
  end

  // Running sum and remaining count after this byte
  assign frame_len = {1'b0, payload_length_i} + scf_pkg::LEN_ADJ;
  assign start_sum = 16'(packet_id_i) + 16'(frame_len[8]) + 16'(frame_len[7:0]);
  assign base_sum  = in_packet_q ? sum_q : start_sum;
  assign new_sum   = base_sum + 16'(data_byte_i);
  assign left_base = in_packet_q ? left_q : payload_length_i;
  assign left_next = left_base - 8'd1;
  assign last      = (left_next == 8'd0);

  // Build the command for the back end
  always_comb begin
    cmd_o.kind   = scf_pkg::KIND_DATA;
    cmd_o.status = scf_pkg::ST_OK;
    if (!in_packet_q) begin
      cmd_o.kind   = (status == scf_pkg::ST_OK) ? scf_pkg::KIND_START
                                                : scf_pkg::KIND_REJECT;
      cmd_o.status = status;
    end
    cmd_o.id   = packet_id_i;
    cmd_o.len  = payload_length_i;
    cmd_o.data = data_byte_i;
    cmd_o.last = last;
    cmd_o.sum  = new_sum;
  end

  assign push_o = accept;

  // Update packet state on each accepted item
  always_comb begin
    in_packet_d = in_packet_q;
    left_d      = left_q;
    sum_d       = sum_q;
    if (accept && (in_packet_q || status == scf_pkg::ST_OK)) begin
      if (last) begin
        in_packet_d = 1'b0;
        left_d      = 8'd0;
        sum_d       = 16'd0;
      end else begin
        in_packet_d = 1'b1;
        left_d      = left_next;
        sum_d       = new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      left_q      <= 8'd0;
      sum_q       <= 16'd0;
    end else begin
      in_packet_q <= in_packet_d;
      left_q      <= left_d;
      sum_q       <= sum_d;
    end
  end

endmodule

// ===== src/scf_back.sv =====
// ----------------------------------------------------------------------------
// scf_back
// Expands queued commands into frame bytes behind an output register.
// ----------------------------------------------------------------------------
module scf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  scf_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  input  logic [31:0]   device_address_i,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [7:0]    m_byte_o,
  output logic          m_end_o,
  output logic [1:0]    m_status_o
);

  scf_pkg::cmd_t               cur_q;
  logic                        cur_valid_q, cur_valid_d;
  logic [scf_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        m_valid_q, m_valid_d;
  logic [7:0]                  byte_q, byte_d;
  logic                        end_q, end_d;
  logic [1:0]                  status_q, status_d;

  logic       out_free, emit, done, load;
  logic [8:0] frame_len;

  assign out_free = !m_valid_q || m_ready_i;
  assign emit     = cur_valid_q && out_free;
  assign done     = (cur_q.kind == scf_pkg::KIND_REJECT)
                 || (step_q == scf_pkg::STEP_DATA && !cur_q.last)
                 || (step_q == scf_pkg::STEP_SUM_LO);
  assign load     = q_valid_i && (!cur_valid_q || (emit && done));
  assign q_pop_o  = load;
  assign frame_len = {1'b0, cur_q.len} + scf_pkg::LEN_ADJ;

  // Select the byte for the current step
  always_comb begin
    byte_d   = 8'd0;
    end_d    = 1'b0;
    status_d = scf_pkg::ST_OK;
    if (cur_q.kind == scf_pkg::KIND_REJECT) begin
      end_d    = 1'b1;
      status_d = cur_q.status;
    end else begin
      case (step_q)
        scf_pkg::STEP_HDR0:   byte_d = scf_pkg::HDR_BYTE0;
        scf_pkg::STEP_HDR1:   byte_d = scf_pkg::HDR_BYTE1;
        scf_pkg::STEP_ADDR3:  byte_d = device_address_i[31:24];
        scf_pkg::STEP_ADDR2:  byte_d = device_address_i[23:16];
        scf_pkg::STEP_ADDR1:  byte_d = device_address_i[15:8];
        scf_pkg::STEP_ADDR0:  byte_d = device_address_i[7:0];
        scf_pkg::STEP_ID:     byte_d = cur_q.id;
        scf_pkg::STEP_LEN_HI: byte_d = {7'd0, frame_len[8]};
        scf_pkg::STEP_LEN_LO: byte_d = frame_len[7:0];
        scf_pkg::STEP_DATA:   byte_d = cur_q.data;
        scf_pkg::STEP_SUM_HI: byte_d = cur_q.sum[15:8];
        scf_pkg::STEP_SUM_LO: begin
          byte_d = cur_q.sum[7:0];
          end_d  = 1'b1;
        end
        default:              byte_d = 8'd0;
      endcase
    end
  end

  // Advance the step or take the next command
  always_comb begin
    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    if (load) begin
      cur_valid_d = 1'b1;
      step_d      = (q_head_i.kind == scf_pkg::KIND_DATA) ? scf_pkg::STEP_DATA
                                                          : scf_pkg::STEP_HDR0;
    end else if (emit && done) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      step_d = step_q + 1'b1;
    end
    m_valid_d = emit ? 1'b1 : (m_ready_i ? 1'b0 : m_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= scf_pkg::STEP_HDR0;
      m_valid_q   <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_head_i;
    end
    if (emit) begin
      byte_q   <= byte_d;
      end_q    <= end_d;
      status_q <= status_d;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_byte_o   = byte_q;
  assign m_end_o    = end_q;
  assign m_status_o = status_q;

endmodule

// ===== src/sensor_command_packet_framer.sv =====
// ----------------------------------------------------------------------------
// sensor_command_packet_framer
// Frames payload bytes into sensor packets with header and 16-bit checksum.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake           | Payload
//  s_*       | in        | s_tvalid / s_tready | id, length, data byte
//  m_*       | out       | m_tvalid / m_tready | frame byte, tlast, status
//  cfg_*     | in        | cfg_valid/cfg_ready | register index, data
//
//  The front takes one item per cycle until the 4-entry command queue fills.
//  The back emits one byte per cycle while m_tready is high. A packet start
//  sends header, address, id, length and first payload byte, each later
//  payload byte itself; the last adds the checksum; a reject one byte.
//  The output byte rate sets the sustained input rate. Reset clears packet
//  state, queue and output valid; the address resets to all ones and the
//  buffer size to zero. Output stalls back up through the queue to s_tready.
// ----------------------------------------------------------------------------
module sensor_command_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // packet_id[7:0], payload_length[15:8], data_byte[23:16]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // out_byte[7:0]
  output logic        m_tlast_o,   // frame_end
  output logic [1:0]  m_tuser_o,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0]   addr_q;
  logic [7:0]    bsize_q;
  logic          push, full, pop, q_valid;
  scf_pkg::cmd_t push_cmd, head_cmd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= 32'hFFFF_FFFF;
      bsize_q <= 8'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == scf_pkg::REG_ADDR) begin
        addr_q <= cfg_data_i;
      end else if (cfg_index_i == scf_pkg::REG_BSIZE) begin
        bsize_q <= cfg_data_i[7:0];
      end
    end
  end

  scf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (s_tvalid_i),
    .ready_o          (s_tready_o),
    .packet_id_i      (s_tdata_i[7:0]),
    .payload_length_i (s_tdata_i[15:8]),
    .data_byte_i      (s_tdata_i[23:16]),
    .buffer_size_i    (bsize_q),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .full_i           (full)
  );

  scf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  scf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (head_cmd),
    .q_pop_o          (pop),
    .device_address_i (addr_q),
    .m_valid_o        (m_tvalid_o),
    .m_ready_i        (m_tready_i),
    .m_byte_o         (m_tdata_o),
    .m_end_o          (m_tlast_o),
    .m_status_o       (m_tuser_o)
  );

endmodule

// ===== src/scf_checker.sv =====
// ----------------------------------------------------------------------------
// scf_checker
// Port-level checks for the sensor command packet framer.
// ----------------------------------------------------------------------------
module scf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i,
  input logic       m_tlast_i,
  input logic [1:0] m_tuser_i
);

  // Error results always close the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && m_tuser_i != scf_pkg::ST_OK) |-> m_tlast_i)
    else $error("error result without tlast");

  // Error results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && m_tuser_i != scf_pkg::ST_OK) |-> (m_tdata_i == 8'd0))
    else $error("error result with nonzero byte");

  // Keep output valid known once out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(m_tvalid_i))
    else $error("output valid unknown");

  // Hold a stalled transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)
                                     && $stable(m_tlast_i) && $stable(m_tuser_i)))
    else $error("stalled output changed");

endmodule

bind sensor_command_packet_framer scf_checker u_scf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tlast_i  (m_tlast_o),
  .m_tuser_i  (m_tuser_o)
);
